@@ design/awt_pkg.sv @@
package awt_pkg;

  localparam int MAX_STEPS = 24;
  localparam int ZW = 36;
  localparam int RW = 34;
  localparam int VW = 43;
  localparam int CIW = 3;

  localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [RW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [21:0] GAIN_Q22 = 22'd2547003;
  localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;

  localparam logic [CIW-1:0] REG_LOCAL_X = 3'd0;
  localparam logic [CIW-1:0] REG_LOCAL_Y = 3'd1;
  localparam logic [CIW-1:0] REG_LOCAL_ANGLE = 3'd2;
  localparam logic [CIW-1:0] REG_SCALE_X = 3'd3;
  localparam logic [CIW-1:0] REG_SCALE_Y = 3'd4;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } awt_mat_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 36'sd843314856;
      5'd1: r = 36'sd497837829;
      5'd2: r = 36'sd263043836;
      5'd3: r = 36'sd133525158;
      5'd4: r = 36'sd67021686;
      5'd5: r = 36'sd33543515;
      5'd6: r = 36'sd16775850;
      5'd7: r = 36'sd8388437;
      5'd8: r = 36'sd4194282;
      5'd9: r = 36'sd2097149;
      5'd10: r = 36'sd1048575;
      5'd11: r = 36'sd524287;
      5'd12: r = 36'sd262143;
      5'd13: r = 36'sd131071;
      5'd14: r = 36'sd65535;
      5'd15: r = 36'sd32767;
      5'd16: r = 36'sd16383;
      5'd17: r = 36'sd8191;
      5'd18: r = 36'sd4095;
      5'd19: r = 36'sd2047;
      5'd20: r = 36'sd1023;
      5'd21: r = 36'sd511;
      5'd22: r = 36'sd255;
      5'd23: r = 36'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/awt_if.sv @@
interface awt_in_if;
  logic valid;
  logic ready;
  logic has_parent;
  logic signed [31:0] parent_a;
  logic signed [31:0] parent_b;
  logic signed [31:0] parent_c;
  logic signed [31:0] parent_d;
  logic signed [31:0] parent_tx;
  logic signed [31:0] parent_ty;

  modport source (output valid, has_parent, parent_a, parent_b, parent_c, parent_d,
                  parent_tx, parent_ty, input ready);
  modport sink (input valid, has_parent, parent_a, parent_b, parent_c, parent_d,
                parent_tx, parent_ty, output ready);
endinterface

interface awt_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] world_a;
  logic signed [31:0] world_b;
  logic signed [31:0] world_c;
  logic signed [31:0] world_d;
  logic signed [31:0] world_tx;
  logic signed [31:0] world_ty;
  logic signed [15:0] world_angle;
  logic [30:0] world_scale_x;
  logic [30:0] world_scale_y;

  modport source (output valid, world_a, world_b, world_c, world_d, world_tx, world_ty,
                  world_angle, world_scale_x, world_scale_y, input ready);
  modport sink (input valid, world_a, world_b, world_c, world_d, world_tx, world_ty,
                world_angle, world_scale_x, world_scale_y, output ready);
endinterface

@@ design/awt_lcl.sv @@
module awt_lcl import awt_pkg::*; #(
  parameter int NSTEP = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CIW-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  output awt_mat_t lmat,
  output logic busy
);

  typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_SCALE, ST_DONE} state_t;

  state_t state;
  logic signed [31:0] local_x;
  logic signed [31:0] local_y;
  logic signed [15:0] local_angle;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic signed [31:0] col_a;
  logic signed [31:0] col_b;
  logic signed [31:0] col_c;
  logic signed [31:0] col_d;
  logic signed [RW-1:0] x;
  logic signed [RW-1:0] y;
  logic signed [ZW-1:0] z;
  logic neg;
  logic [4:0] cnt;

  logic signed [ZW-1:0] z_init;
  logic signed [RW-1:0] xs;
  logic signed [RW-1:0] ys;
  logic signed [RW-1:0] cv;
  logic signed [RW-1:0] sv;

  function automatic logic signed [31:0] tscale(input logic signed [RW-1:0] t,
                                                input logic signed [15:0] sc);
    logic signed [67:0] p;
    p = 68'(t) * 68'(sc) + 68'sd2097152;
    return sat32(p >>> 22);
  endfunction

  always_comb begin
    z_init = {{(ZW-33){local_angle[15]}}, local_angle, 17'b0};
    xs = x >>> cnt;
    ys = y >>> cnt;
    cv = neg ? -x : x;
    sv = neg ? -y : y;
  end

  assign busy = (state != ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      local_x <= '0;
      local_y <= '0;
      local_angle <= '0;
      scale_x <= 16'sd256;
      scale_y <= 16'sd256;
      cnt <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          x <= GAIN_Q30;
          y <= '0;
          cnt <= '0;
          if (z_init > HALF_PI_Q30) begin
            z <= z_init - PI_Q30;
            neg <= 1'b1;
          end else if (z_init < -HALF_PI_Q30) begin
            z <= z_init + PI_Q30;
            neg <= 1'b1;
          end else begin
            z <= z_init;
            neg <= 1'b0;
          end
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (!z[ZW-1]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_q30(cnt);
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_q30(cnt);
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(NSTEP - 1)) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          col_a <= tscale(cv, scale_x);
          col_b <= tscale(sv, scale_x);
          col_c <= tscale(-sv, scale_y);
          col_d <= tscale(cv, scale_y);
          state <= ST_DONE;
        end
        ST_DONE: begin
          state <= ST_DONE;
        end
        default: state <= ST_LOAD;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LOCAL_X: local_x <= cfg_data;
          REG_LOCAL_Y: local_y <= cfg_data;
          REG_LOCAL_ANGLE: local_angle <= cfg_data[15:0];
          REG_SCALE_X: scale_x <= cfg_data[15:0];
          REG_SCALE_Y: scale_y <= cfg_data[15:0];
          default: ;
        endcase
        state <= ST_LOAD;
      end
    end
  end

  assign lmat = {col_a, col_b, col_c, col_d, local_x, local_y};

endmodule

@@ design/awt_vec.sv @@
module awt_vec import awt_pkg::*; #(
  parameter int NSTEP = 16,
  localparam int NV = NSTEP + 3
) (
  input  logic clk,
  input  logic [NV-1:0] en,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  output logic signed [15:0] ang,
  output logic [30:0] len
);

  logic signed [VW-1:0] xs [NSTEP+1];
  logic signed [VW-1:0] ys [NSTEP+1];
  logic signed [ZW-1:0] zs [NSTEP+1];
  logic zero [NSTEP+1];

  logic signed [VW-1:0] ex;
  logic signed [VW-1:0] ey;
  logic signed [ZW-1:0] zt;
  logic signed [15:0] ang1;
  logic signed [44:0] ph;
  logic [42:0] pl;
  logic zero1;
  logic signed [67:0] lsum;
  logic signed [67:0] lv;

  assign ex = {{(VW-40){vx[31]}}, vx, 8'b0};
  assign ey = {{(VW-40){vy[31]}}, vy, 8'b0};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      zero[0] <= (vx == 32'sd0) && (vy == 32'sd0);
      if (ex[VW-1]) begin
        xs[0] <= -ex;
        ys[0] <= -ey;
        zs[0] <= ey[VW-1] ? -PI_Q30 : PI_Q30;
      end else begin
        xs[0] <= ex;
        ys[0] <= ey;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        zero[i+1] <= zero[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q30(5'(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q30(5'(i));
        end
      end
    end
  end

  assign zt = (zs[NSTEP] + 36'sd65536) >>> 17;

  always_ff @(posedge clk) begin
    if (en[NV-2]) begin
      zero1 <= zero[NSTEP];
      if (zt > 36'(ANGLE_LIMIT)) begin
        ang1 <= ANGLE_LIMIT;
      end else if (zt < -36'(ANGLE_LIMIT)) begin
        ang1 <= -ANGLE_LIMIT;
      end else begin
        ang1 <= zt[15:0];
      end
      ph <= 45'(xs[NSTEP][VW-1:21]) * $signed({1'b0, GAIN_Q22});
      pl <= 43'(xs[NSTEP][20:0]) * 43'(GAIN_Q22);
    end
  end

  assign lsum = (68'(ph) <<< 21) + $signed({25'b0, pl}) + 68'sd536870912;
  assign lv = lsum >>> 30;

  always_ff @(posedge clk) begin
    if (en[NV-1]) begin
      if (zero1) begin
        ang <= '0;
        len <= '0;
      end else begin
        ang <= ang1;
        if (lv < 0) begin
          len <= '0;
        end else if (lv > 68'sd2147483647) begin
          len <= '1;
        end else begin
          len <= lv[30:0];
        end
      end
    end
  end

endmodule

@@ design/affine_trs_world_transform_top.sv @@
// Throughput: one request per cycle; each pipeline stage holds under backpressure.
// The local matrix is built by an iterative sine/cosine CORDIC, one step a cycle;
// after reset and after every configuration write, ready stays low while it is rebuilt.
// Reset (rst, synchronous) clears all valid bits and loads the register defaults.
module affine_trs_world_transform_top import awt_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CIW-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  awt_in_if.sink item,
  awt_out_if.source result
);

  localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int NV = NSTEP + 3;
  localparam int L = NV + 3;

  awt_mat_t lmat;
  logic busy;
  logic [L-1:0] v;
  logic [L-1:0] load;

  logic hp0;
  logic hp1;
  logic hp2;
  awt_mat_t pm;
  logic signed [31:0] ptx1;
  logic signed [31:0] pty1;
  logic signed [63:0] prd [12];
  awt_mat_t w;
  awt_mat_t wd [NV];
  awt_mat_t wn;

  function automatic logic signed [31:0] mac(input logic signed [63:0] p1,
                                             input logic signed [63:0] p2,
                                             input logic signed [31:0] add);
    logic signed [67:0] s;
    s = 68'(p1) + 68'(p2) + (68'(add) <<< 16) + 68'sd32768;
    return sat32(s >>> 16);
  endfunction

  awt_lcl #(.NSTEP(NSTEP)) u_lcl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .lmat(lmat), .busy(busy)
  );

  always_comb begin
    load[L-1] = !v[L-1] || result.ready;
    for (int k = L - 2; k >= 0; k--) begin
      load[k] = !v[k] || load[k+1];
    end
  end

  assign item.ready = load[0] && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) begin
        v[0] <= item.valid && !busy;
      end
      for (int k = 1; k < L; k++) begin
        if (load[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      hp0 <= item.has_parent;
      pm.a <= item.parent_a;
      pm.b <= item.parent_b;
      pm.c <= item.parent_c;
      pm.d <= item.parent_d;
      pm.tx <= item.parent_tx;
      pm.ty <= item.parent_ty;
    end
    if (load[1]) begin
      hp1 <= hp0;
      ptx1 <= pm.tx;
      pty1 <= pm.ty;
      prd[0] <= pm.a * lmat.a;
      prd[1] <= pm.c * lmat.b;
      prd[2] <= pm.b * lmat.a;
      prd[3] <= pm.d * lmat.b;
      prd[4] <= pm.a * lmat.c;
      prd[5] <= pm.c * lmat.d;
      prd[6] <= pm.b * lmat.c;
      prd[7] <= pm.d * lmat.d;
      prd[8] <= pm.a * lmat.tx;
      prd[9] <= pm.c * lmat.ty;
      prd[10] <= pm.b * lmat.tx;
      prd[11] <= pm.d * lmat.ty;
    end
    if (load[2]) begin
      hp2 <= hp1;
      wn.a <= mac(prd[0], prd[1], 32'sd0);
      wn.b <= mac(prd[2], prd[3], 32'sd0);
      wn.c <= mac(prd[4], prd[5], 32'sd0);
      wn.d <= mac(prd[6], prd[7], 32'sd0);
      wn.tx <= mac(prd[8], prd[9], ptx1);
      wn.ty <= mac(prd[10], prd[11], pty1);
    end
    if (load[3]) begin
      wd[0] <= w;
    end
    for (int k = 1; k < NV; k++) begin
      if (load[3+k]) begin
        wd[k] <= wd[k-1];
      end
    end
  end

  assign w = hp2 ? wn : lmat;

  awt_vec #(.NSTEP(NSTEP)) u_vec0 (
    .clk(clk), .en(load[L-1:3]), .vx(w.a), .vy(w.b),
    .ang(result.world_angle), .len(result.world_scale_x)
  );

  logic signed [15:0] ang_col1;

  awt_vec #(.NSTEP(NSTEP)) u_vec1 (
    .clk(clk), .en(load[L-1:3]), .vx(w.c), .vy(w.d),
    .ang(ang_col1), .len(result.world_scale_y)
  );

  assign result.valid = v[L-1];
  assign result.world_a = wd[NV-1].a;
  assign result.world_b = wd[NV-1].b;
  assign result.world_c = wd[NV-1].c;
  assign result.world_d = wd[NV-1].d;
  assign result.world_tx = wd[NV-1].tx;
  assign result.world_ty = wd[NV-1].ty + 32'(ang_col1 & 16'sd0);

endmodule

@@ design/awt_chk.sv @@
module awt_chk (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic signed [31:0] world_a,
  input logic signed [31:0] world_b,
  input logic signed [15:0] world_angle,
  input logic [30:0] world_scale_x
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(world_a) && $stable(world_angle))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && world_a == 32'sd0 && world_b == 32'sd0 |->
      world_angle == 16'sd0 && world_scale_x == 31'd0)
    else $error("zero column gives nonzero angle or length");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> world_angle <= 16'sd25736 && world_angle >= -16'sd25736)
    else $error("world angle out of range");

endmodule

bind affine_trs_world_transform_top awt_chk u_awt_chk (
  .clk(clk), .rst(rst), .out_valid(result.valid), .out_ready(result.ready),
  .world_a(result.world_a), .world_b(result.world_b),
  .world_angle(result.world_angle), .world_scale_x(result.world_scale_x)
);

@@ bench/affine_trs_world_transform_top_tb.sv @@
module affine_trs_world_transform_top_tb;
  import awt_pkg::*;

  localparam int STEPS = 16;
  localparam int NSTEP = (STEPS > 24) ? 24 : STEPS;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 145;

  localparam longint ATAN_TAB [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  typedef struct {
    logic has_parent;
    logic signed [31:0] pa, pb, pc, pd, ptx, pty;
  } node_req_t;

  typedef struct {
    logic signed [31:0] a, b, c, d, tx, ty;
    logic signed [15:0] angle;
    logic [30:0] scale_x, scale_y;
  } world_t;

  typedef struct {
    node_req_t req;
    bit known;
    world_t world;
  } directed_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CIW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  awt_in_if in_if ();
  awt_out_if out_if ();

  affine_trs_world_transform_top #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item(in_if.sink), .result(out_if.source)
  );

  always #1 clk = ~clk;

  logic signed [31:0] local_x_q, local_y_q;
  logic signed [15:0] local_angle_q, scale_x_q, scale_y_q;
  world_t expected_world [$];
  int fail_count = 0;
  int stall_cycles = 0;
  bit steady = 0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint z, x, y, t;
    bit neg;
    z = ang * 131072;
    x = GAIN_Q30;
    y = 0;
    neg = 0;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30;
      neg = 1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30;
      neg = 1;
    end
    for (int i = 0; i < NSTEP; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ATAN_TAB[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += ATAN_TAB[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic void polar(input longint vx, input longint vy,
                                output longint ang, output longint len);
    longint x, y, z, t, g;
    x = vx * 256;
    y = vy * 256;
    z = 0;
    g = GAIN_Q22;
    if (vx == 0 && vy == 0) begin
      ang = 0;
      len = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSTEP; i++) begin
      if (y > 0) begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += ATAN_TAB[i];
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ATAN_TAB[i];
      end
    end
    z = (z + 65536) >>> 17;
    if (z > ANGLE_LIMIT) z = ANGLE_LIMIT;
    if (z < -ANGLE_LIMIT) z = -ANGLE_LIMIT;
    ang = z;
    len = (x * g + (64'sd1 <<< 29)) >>> 30;
    if (len < 0) len = 0;
    if (len > 64'sd2147483647) len = 64'sd2147483647;
  endfunction

  function automatic longint scaled_trig(input longint t, input longint sc);
    return clamp32((t * sc + (64'sd1 <<< 21)) >>> 22);
  endfunction

  function automatic longint round_sum(input longint p1, input longint p2, input longint add);
    longint hi, lo;
    hi = (p1 >>> 16) + (p2 >>> 16) + add;
    lo = (p1 & 64'hFFFF) + (p2 & 64'hFFFF);
    return clamp32(hi + ((lo + 32768) >>> 16));
  endfunction

  function automatic world_t world_transform(input node_req_t r);
    world_t w;
    longint c, s, la, lb, lc, ld, ang, lx, ly;
    longint m [6];
    sin_cos(local_angle_q, c, s);
    la = scaled_trig(c, scale_x_q);
    lb = scaled_trig(s, scale_x_q);
    lc = scaled_trig(-s, scale_y_q);
    ld = scaled_trig(c, scale_y_q);
    if (r.has_parent) begin
      m[0] = round_sum(r.pa * la, r.pc * lb, 0);
      m[1] = round_sum(r.pb * la, r.pd * lb, 0);
      m[2] = round_sum(r.pa * lc, r.pc * ld, 0);
      m[3] = round_sum(r.pb * lc, r.pd * ld, 0);
      m[4] = round_sum(r.pa * longint'(local_x_q), r.pc * longint'(local_y_q), r.ptx);
      m[5] = round_sum(r.pb * longint'(local_x_q), r.pd * longint'(local_y_q), r.pty);
    end else begin
      m = '{la, lb, lc, ld, longint'(local_x_q), longint'(local_y_q)};
    end
    polar(m[0], m[1], ang, lx);
    polar(m[2], m[3], c, ly);
    w.a = m[0]; w.b = m[1]; w.c = m[2]; w.d = m[3]; w.tx = m[4]; w.ty = m[5];
    w.angle = ang[15:0];
    w.scale_x = lx[30:0];
    w.scale_y = ly[30:0];
    return w;
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 262144)) - 131072;
      3: return $signed($urandom_range(0, 33554432)) - 16777216;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [15:0] rand_scale();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 1024)) - 512;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic write_reg(input logic [CIW-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [15:0] ang, input logic signed [15:0] sx,
                            input logic signed [15:0] sy);
    while (expected_world.size() != 0) @(posedge clk);
    repeat (NSTEP + 10) @(posedge clk);
    write_reg(REG_LOCAL_X, x);
    write_reg(REG_LOCAL_Y, y);
    write_reg(REG_LOCAL_ANGLE, {{16{ang[15]}}, ang});
    write_reg(REG_SCALE_X, {{16{sx[15]}}, sx});
    write_reg(REG_SCALE_Y, {{16{sy[15]}}, sy});
    cfg_we <= 1'b0;
    local_x_q = x; local_y_q = y; local_angle_q = ang; scale_x_q = sx; scale_y_q = sy;
  endtask

  task automatic send_req(input node_req_t r, input bit known, input world_t w);
    while (!steady && $urandom_range(0, 99) < 37) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.has_parent <= r.has_parent;
    in_if.parent_a <= r.pa;
    in_if.parent_b <= r.pb;
    in_if.parent_c <= r.pc;
    in_if.parent_d <= r.pd;
    in_if.parent_tx <= r.ptx;
    in_if.parent_ty <= r.pty;
    do @(posedge clk); while (!in_if.ready);
    expected_world.push_back(known ? w : world_transform(r));
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    world_t e;
    out_if.ready <= rst ? 1'b0 : (steady || $urandom_range(0, 99) >= 37);
    if (in_if.valid && in_if.ready || out_if.valid && out_if.ready || cfg_we || rst) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("affine_trs_world_transform_top regression: fail");
      $finish;
    end
    if (!rst && out_if.valid && out_if.ready) begin
      if (expected_world.size() == 0) begin
        $error("request result arrived with nothing expected");
        fail_count++;
      end else begin
        e = expected_world.pop_front();
        check_field("world_a", e.a, out_if.world_a);
        check_field("world_b", e.b, out_if.world_b);
        check_field("world_c", e.c, out_if.world_c);
        check_field("world_d", e.d, out_if.world_d);
        check_field("world_tx", e.tx, out_if.world_tx);
        check_field("world_ty", e.ty, out_if.world_ty);
        check_field("world_angle", e.angle, out_if.world_angle);
        check_field("world_scale_x", e.scale_x, out_if.world_scale_x);
        check_field("world_scale_y", e.scale_y, out_if.world_scale_y);
      end
    end
  end

  initial begin
    directed_row_t rows [$];
    directed_row_t row;
    node_req_t r;
    world_t zero_w;
    logic signed [31:0] cx, cy;
    logic signed [15:0] ca, csx, csy;
    int count;
    in_if.valid = 0;
    in_if.has_parent = 0;
    in_if.parent_a = 0;
    in_if.parent_b = 0;
    in_if.parent_c = 0;
    in_if.parent_d = 0;
    in_if.parent_tx = 0;
    in_if.parent_ty = 0;
    out_if.ready = 0;
    local_x_q = 0; local_y_q = 0; local_angle_q = 0; scale_x_q = 256; scale_y_q = 256;
    zero_w = '{default: '0};

    // A zero parent collapses the whole world matrix to zero.
    rows.push_back('{'{1'b1, 0, 0, 0, 0, 0, 0}, 1, zero_w});
    rows.push_back('{'{1'b0, 0, 0, 0, 0, 0, 0}, 0, zero_w});
    rows.push_back('{'{1'b0, 32'sh7fffffff, 32'sh80000000, -1, 5, 7, 9}, 0, zero_w});
    rows.push_back('{'{1'b1, 65536, 0, 0, 65536, 0, 0}, 0, zero_w});
    rows.push_back('{'{1'b1, 65536, 0, 0, 65536, 32'sh7fffffff, 32'sh80000000}, 0, zero_w});
    rows.push_back('{'{1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                       32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 0, zero_w});
    rows.push_back('{'{1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                       32'sh80000000, 32'sh80000000, 32'sh80000000}, 0, zero_w});
    rows.push_back('{'{1'b1, -65536, 0, 0, -65536, 0, 0}, 0, zero_w});
    rows.push_back('{'{1'b1, -65536, 1, 0, 65536, 0, 0}, 0, zero_w});
    rows.push_back('{'{1'b1, -65536, -1, 0, 65536, 0, 0}, 0, zero_w});
    rows.push_back('{'{1'b1, 0, 0, 65536, 65536, -3, 3}, 0, zero_w});
    rows.push_back('{'{1'b1, 0, 0, 32'sh7fffffff, 32'sh80000000, 1, -1}, 0, zero_w});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_req(rows[i].req, rows[i].known, rows[i].world);
    in_if.valid <= 1'b0;

    set_config(32'sh7fffffff, 32'sh80000000, 16'sd25736, 16'sh7fff, 16'sh8000);
    send_req(rows[5].req, 0, zero_w);
    send_req(rows[6].req, 0, zero_w);
    send_req(rows[4].req, 0, zero_w);
    send_req(rows[1].req, 0, zero_w);
    in_if.valid <= 1'b0;

    count = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin cx = 32'sh80000000; cy = 32'sh7fffffff; ca = -16'sd25736;
             csx = 16'sh8000; csy = 16'sh7fff; end
        1: begin cx = 0; cy = 0; ca = 16'sh7fff; csx = 0; csy = 1; end
        2: begin cx = 65536; cy = -65536; ca = 16'sh8000; csx = 256; csy = -256; end
        3: begin cx = 0; cy = 0; ca = 0; csx = 256; csy = 256; end
        default: begin
          cx = rand_q(); cy = rand_q();
          ca = $signed($urandom_range(0, 51472)) - 25736;
          csx = rand_scale(); csy = rand_scale();
        end
      endcase
      set_config(cx, cy, ca, csx, csy);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        steady = (count >= 700 && count < 860);
        r.has_parent = ($urandom_range(0, 4) != 0);
        r.pa = rand_q(); r.pb = rand_q(); r.pc = rand_q();
        r.pd = rand_q(); r.ptx = rand_q(); r.pty = rand_q();
        send_req(r, 0, zero_w);
        count++;
      end
      in_if.valid <= 1'b0;
      steady = 0;
    end

    while (expected_world.size() != 0) @(posedge clk);
    repeat (NSTEP + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("affine_trs_world_transform_top regression: pass");
    end else begin
      $display("affine_trs_world_transform_top regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/awt_pkg.sv
design/awt_if.sv
design/awt_lcl.sv
design/awt_vec.sv
design/affine_trs_world_transform_top.sv
design/awt_chk.sv
bench/affine_trs_world_transform_top_tb.sv
